[design/rcbcd_pkg.sv]
`timescale 1ns / 1ps

package rcbcd_pkg;

  localparam int LEVEL_W   = 16;
  localparam int INERTIA_W = 8;
  localparam int HOLD_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_US  = 2'd2;

  localparam logic signed [LEVEL_W-1:0] ACTIVE_LEVEL_RST = 16'sd16384;
  localparam logic [INERTIA_W-1:0]      INERTIA_LIMIT_RST = 8'd3;
  localparam logic [HOLD_W-1:0]         HOLD_TIME_US_RST  = 24'd500000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam int RESULT_W  = 5;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] active_level;
    logic [INERTIA_W-1:0]      inertia_limit;
    logic [HOLD_W-1:0]         hold_time_us;
  } cfg_t;

  typedef struct packed {
    logic long_press;
    logic double_click;
    logic single_click;
    logic lazy_state;
    logic raw_state;
  } result_t;

endpackage

[design/rcbcd_front.sv]
`timescale 1ns / 1ps

module rcbcd_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rcbcd_pkg::cfg_t                cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [TIME_WIDTH-1:0]          now_us,
  output logic                           fwd_valid,
  input  logic                           fwd_ready,
  output logic [TIME_WIDTH:0]            fwd_data
);

  localparam int DIFF_W = ((SAMPLE_WIDTH > rcbcd_pkg::LEVEL_W) ?
                           SAMPLE_WIDTH : rcbcd_pkg::LEVEL_W) + 1;
  localparam int PROD_W = DIFF_W + 3;

  logic signed [DIFF_W-1:0] sample_ext;
  logic signed [DIFF_W-1:0] level_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic [DIFF_W-1:0]        level_mag;
  logic [PROD_W-1:0]        diff_x5;
  logic                     active;

  logic                     stage_valid;
  logic                     stage_active;
  logic [TIME_WIDTH-1:0]    stage_now;

  // Active when five times the distance to the level is within the level's size.
  always_comb begin
    sample_ext = DIFF_W'(sample);
    level_ext  = DIFF_W'(cfg.active_level);
    diff       = sample_ext - level_ext;
    diff_mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    level_mag  = level_ext[DIFF_W-1] ? DIFF_W'(-level_ext) : DIFF_W'(level_ext);
    diff_x5    = {diff_mag, 2'b00} + PROD_W'(diff_mag);
    active     = diff_x5 <= PROD_W'(level_mag);
  end

  assign in_ready  = !stage_valid || fwd_ready;
  assign fwd_valid = stage_valid;
  assign fwd_data  = {stage_now, stage_active};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_active <= active;
      stage_now    <= now_us;
    end
  end

endmodule

[design/rcbcd_queue.sv]
`timescale 1ns / 1ps

module rcbcd_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0]                    entries [rcbcd_pkg::QUEUE_DEPTH];
  logic [rcbcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [rcbcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [rcbcd_pkg::QUEUE_CNT_W-1:0]   count;
  logic                                push;
  logic                                pop;

  assign in_ready  = count < rcbcd_pkg::QUEUE_CNT_W'(rcbcd_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

[design/rcbcd_back.sv]
`timescale 1ns / 1ps

module rcbcd_back #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rcbcd_pkg::cfg_t     cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_WIDTH:0] in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcbcd_pkg::result_t  result
);

  localparam int CMP_W = (TIME_WIDTH > rcbcd_pkg::HOLD_W) ? TIME_WIDTH : rcbcd_pkg::HOLD_W;

  logic                            active;
  logic [TIME_WIDTH-1:0]           now;
  logic [TIME_WIDTH-1:0]           elapsed;
  logic                            quiet;
  logic                            fire;

  logic [rcbcd_pkg::INERTIA_W-1:0] inertia_count;
  logic                            debounced;
  logic                            previous_debounced;
  logic                            lazy;
  logic                            click_armed;
  logic                            click_pending;
  logic [TIME_WIDTH-1:0]           last_edge_time;

  logic [rcbcd_pkg::INERTIA_W-1:0] inertia_count_next;
  logic                            debounced_next;
  logic                            lazy_next;
  logic                            click_armed_next;
  logic                            click_pending_next;
  logic [TIME_WIDTH-1:0]           last_edge_time_next;
  logic                            single_next;
  logic                            double_next;
  logic                            long_next;

  assign active   = in_data[0];
  assign now      = in_data[TIME_WIDTH:1];
  assign elapsed  = now - last_edge_time;
  assign quiet    = CMP_W'(elapsed) > CMP_W'(cfg.hold_time_us);
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    inertia_count_next  = inertia_count;
    debounced_next      = debounced;
    lazy_next           = lazy;
    click_armed_next    = click_armed;
    click_pending_next  = click_pending;
    last_edge_time_next = last_edge_time;
    single_next         = 1'b0;
    double_next         = 1'b0;
    long_next           = 1'b0;

    if (!active) begin
      inertia_count_next = '0;
      debounced_next     = 1'b0;
    end else if (inertia_count < cfg.inertia_limit) begin
      inertia_count_next = inertia_count + 1'b1;
    end else begin
      debounced_next = 1'b1;
    end

    if (debounced_next != previous_debounced) begin
      last_edge_time_next = now;
      if (debounced_next) begin
        click_armed_next = 1'b1;
      end else begin
        lazy_next = 1'b0;
        if (click_armed) begin
          double_next        = click_pending;
          click_pending_next = !click_pending;
          click_armed_next   = 1'b0;
        end
      end
    end else if (quiet) begin
      long_next          = debounced_next && !lazy;
      lazy_next          = debounced_next;
      single_next        = !debounced_next && click_pending;
      click_pending_next = 1'b0;
      click_armed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      inertia_count      <= '0;
      debounced          <= 1'b0;
      previous_debounced <= 1'b0;
      lazy               <= 1'b0;
      click_armed        <= 1'b0;
      click_pending      <= 1'b0;
      last_edge_time     <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        inertia_count      <= inertia_count_next;
        debounced          <= debounced_next;
        previous_debounced <= debounced_next;
        lazy               <= lazy_next;
        click_armed        <= click_armed_next;
        click_pending      <= click_pending_next;
        last_edge_time     <= last_edge_time_next;
      end
    end
    if (fire) begin
      result.raw_state    <= debounced_next;
      result.lazy_state   <= lazy_next;
      result.single_click <= single_next;
      result.double_click <= double_next;
      result.long_press   <= long_next;
    end
  end

endmodule

[design/rc_button_click_detector.sv]
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tdata: sample, now_us, zero padding to whole bytes
// m_axis    out        tdata: raw_state, lazy_state, single_click, double_click,
//                      long_press, zero padding
// cfg       in         cfg_wr_en, cfg_addr, cfg_wr_data; one write per enabled cycle
//
// One beat in and one beat out per clock at full rate, while the output is not stalled;
// a beat passes the classify stage, the two-entry queue and the result register.
// The per-sample state update in the back end is combinational and is registered on each accepted beat.
// Reset restores the register defaults and clears all detector state.
// The front end and back end stall separately; the two-entry queue absorbs the skew between them.

module rc_button_click_detector #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: sample, now_us, zero padding.
  input  logic [((SAMPLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0: raw_state, lazy_state, single_click, double_click, long_press.
  output logic [rcbcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [rcbcd_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [rcbcd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  rcbcd_pkg::cfg_t    cfg;
  rcbcd_pkg::result_t result;

  logic                fwd_valid;
  logic                fwd_ready;
  logic [TIME_WIDTH:0] fwd_data;
  logic                q_valid;
  logic                q_ready;
  logic [TIME_WIDTH:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level  <= rcbcd_pkg::ACTIVE_LEVEL_RST;
      cfg.inertia_limit <= rcbcd_pkg::INERTIA_LIMIT_RST;
      cfg.hold_time_us  <= rcbcd_pkg::HOLD_TIME_US_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rcbcd_pkg::REG_ACTIVE_LEVEL: begin
          cfg.active_level <= cfg_wr_data[rcbcd_pkg::LEVEL_W-1:0];
        end
        rcbcd_pkg::REG_INERTIA_LIMIT: begin
          cfg.inertia_limit <= cfg_wr_data[rcbcd_pkg::INERTIA_W-1:0];
        end
        rcbcd_pkg::REG_HOLD_TIME_US: begin
          cfg.hold_time_us <= cfg_wr_data[rcbcd_pkg::HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rcbcd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sample   (s_tdata[SAMPLE_WIDTH-1:0]),
    .now_us   (s_tdata[SAMPLE_WIDTH +: TIME_WIDTH]),
    .fwd_valid(fwd_valid),
    .fwd_ready(fwd_ready),
    .fwd_data (fwd_data)
  );

  rcbcd_queue #(
    .WIDTH(TIME_WIDTH + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fwd_valid),
    .in_ready (fwd_ready),
    .in_data  (fwd_data),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  rcbcd_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_data  (q_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .result   (result)
  );

  assign m_tdata = {(rcbcd_pkg::OUT_TDATA_W - rcbcd_pkg::RESULT_W)'(0), result};

  a_single_double_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result.single_click && result.double_click))
    else $error("single and double click reported on the same beat");

  a_long_press_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.long_press) |-> (result.lazy_state && result.raw_state))
    else $error("long press without a held, confirmed state");

  a_double_on_release: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.double_click) |-> (!result.raw_state && !result.lazy_state))
    else $error("double click reported while the button is pressed");

  a_single_released: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.single_click) |-> !result.raw_state)
    else $error("single click reported while the button is pressed");

endmodule

[tb/rc_button_click_detector_chk.sv]
`timescale 1ns / 1ps

module rc_button_click_detector_chk #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 32,
  parameter int IN_W         = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // Fields from bit 0: sample, now_us.
  input  logic [IN_W-1:0]                   s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: raw_state, lazy_state, single_click, double_click, long_press.
  input  logic [rcbcd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rcbcd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [rcbcd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  output int                                pending,
  output int                                errors
);

  rcbcd_pkg::cfg_t                  regs;
  logic [rcbcd_pkg::INERTIA_W-1:0]  active_run;
  logic                             pressed;
  logic                             pressed_prev;
  logic                             held;
  logic                             armed;
  logic                             click_waiting;
  logic [TIME_WIDTH-1:0]            last_edge;
  rcbcd_pkg::result_t               outcome_q[$];
  logic [rcbcd_pkg::RESULT_W-1:0]   got;
  logic [rcbcd_pkg::RESULT_W-1:0]   want;
  int                               mismatches = 0;
  string                            field_name[rcbcd_pkg::RESULT_W] =
    '{"raw_state", "lazy_state", "single_click", "double_click", "long_press"};

  function automatic rcbcd_pkg::result_t detect_step(
    input logic signed [SAMPLE_WIDTH-1:0] smp,
    input logic [TIME_WIDTH-1:0] now);
    rcbcd_pkg::result_t    r;
    int                    lvl;
    int                    dev;
    logic [TIME_WIDTH-1:0] quiet;
    r = '0;
    lvl = int'($signed(regs.active_level));
    dev = int'(smp) - lvl;
    if (dev < 0) dev = -dev;
    if (lvl < 0) lvl = -lvl;
    if (5 * dev > lvl) begin
      active_run = '0;
      pressed = 1'b0;
    end else if (active_run < regs.inertia_limit) begin
      active_run = active_run + 1'b1;
    end else begin
      pressed = 1'b1;
    end
    quiet = now - last_edge;
    if (pressed != pressed_prev) begin
      last_edge = now;
      if (pressed) begin
        armed = 1'b1;
      end else begin
        held = 1'b0;
        // A second armed release within the sequence completes a double click.
        if (armed) begin
          r.double_click = click_waiting;
          click_waiting = !click_waiting;
          armed = 1'b0;
        end
      end
      pressed_prev = pressed;
    end else if (quiet > TIME_WIDTH'(regs.hold_time_us)) begin
      r.long_press = pressed && !held;
      held = pressed;
      r.single_click = !pressed && click_waiting;
      click_waiting = 1'b0;
      armed = 1'b0;
    end
    r.raw_state = pressed;
    r.lazy_state = held;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.active_level = rcbcd_pkg::ACTIVE_LEVEL_RST;
      regs.inertia_limit = rcbcd_pkg::INERTIA_LIMIT_RST;
      regs.hold_time_us = rcbcd_pkg::HOLD_TIME_US_RST;
      active_run = '0;
      pressed = 1'b0;
      pressed_prev = 1'b0;
      held = 1'b0;
      armed = 1'b0;
      click_waiting = 1'b0;
      last_edge = '0;
      outcome_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          rcbcd_pkg::REG_ACTIVE_LEVEL:
            regs.active_level = cfg_wr_data[rcbcd_pkg::LEVEL_W-1:0];
          rcbcd_pkg::REG_INERTIA_LIMIT:
            regs.inertia_limit = cfg_wr_data[rcbcd_pkg::INERTIA_W-1:0];
          rcbcd_pkg::REG_HOLD_TIME_US:
            regs.hold_time_us = cfg_wr_data[rcbcd_pkg::HOLD_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(detect_step(s_tdata[SAMPLE_WIDTH-1:0],
                                        s_tdata[SAMPLE_WIDTH +: TIME_WIDTH]));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[rcbcd_pkg::RESULT_W-1:0];
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat %b arrived with nothing expected", $time, got);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          for (int b = 0; b < rcbcd_pkg::RESULT_W; b++) begin
            if (got[b] !== want[b]) begin
              $display("%0t: %s expected %b, got %b", $time, field_name[b], want[b], got[b]);
              mismatches++;
            end
          end
        end
      end
    end
    pending <= outcome_q.size();
    errors <= mismatches;
  end

endmodule

[tb/rc_button_click_detector_tb.sv]
`timescale 1ns / 1ps

module rc_button_click_detector_tb;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TIME_WIDTH = 32;
  localparam int IN_W = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8;
  localparam logic [rcbcd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [IN_W-1:0]                   s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [rcbcd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              cfg_wr_en = 1'b0;
  logic [rcbcd_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [rcbcd_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
  int                                pending;
  int                                errors;

  logic signed [rcbcd_pkg::LEVEL_W-1:0] level_set = rcbcd_pkg::ACTIVE_LEVEL_RST;
  logic [rcbcd_pkg::INERTIA_W-1:0]      inertia_set = rcbcd_pkg::INERTIA_LIMIT_RST;
  logic [rcbcd_pkg::HOLD_W-1:0]         hold_set = rcbcd_pkg::HOLD_TIME_US_RST;
  logic [TIME_WIDTH-1:0]                now_us = '0;
  int                                   burst_left = 0;
  int                                   beats_sent = 0;
  bit                                   gaps_on = 1'b1;
  bit                                   long_hold_req = 1'b0;

  always #5 clk = ~clk;

  rc_button_click_detector #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  rc_button_click_detector_chk #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    #5_000_000;
    $display("rc_button_click_detector regression: fail");
    $finish;
  end

  // The result side stalls in stretches of its own and honors a long hold-off on request.
  initial begin : sink_stall
    int mode;
    int span;
    int hold_left;
    mode = 0;
    span = 0;
    hold_left = 0;
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(8, 60);
        end
        span--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (span % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  function automatic logic [rcbcd_pkg::LEVEL_W-1:0] near_level(input bit in_band);
    int lvl;
    int tol;
    int off;
    int v;
    lvl = int'(level_set);
    tol = (lvl < 0 ? -lvl : lvl) / 5;
    if (in_band) begin
      case ($urandom_range(0, 3))
        0: off = tol;
        1: off = -tol;
        default: off = int'($urandom_range(0, 2 * tol)) - tol;
      endcase
    end else begin
      off = ($urandom_range(0, 1) != 0) ? tol + 1 : -tol - 1;
    end
    v = lvl + off;
    if (v > 32767 || v < -32768) v = lvl - off;
    return v[rcbcd_pkg::LEVEL_W-1:0];
  endfunction

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] smp,
                             input logic [TIME_WIDTH-1:0] dt);
    int gap;
    now_us = now_us + dt;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {now_us, smp};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic run_of(input bit act, input int n, input bit slow);
    logic [SAMPLE_WIDTH-1:0] smp;
    for (int k = 0; k < n; k++) begin
      if (act) smp = near_level(1'b1);
      else if ($urandom_range(0, 2) == 0) smp = SAMPLE_WIDTH'($urandom);
      else smp = near_level(1'b0);
      send_sample(smp, slow ? TIME_WIDTH'(hold_set) + TIME_WIDTH'($urandom_range(1, 2000))
                            : TIME_WIDTH'($urandom_range(0, hold_set / 8)));
    end
  endtask

  task automatic click();
    run_of(1'b1, inertia_set + 1 + $urandom_range(0, 3), 1'b0);
    run_of(1'b0, $urandom_range(1, 3), 1'b0);
  endtask

  task automatic random_sequence();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: click();
      4: begin
        click();
        run_of(1'b0, 1, 1'b1);
      end
      5: begin
        run_of(1'b1, inertia_set + 1, 1'b0);
        run_of(1'b1, $urandom_range(1, 2), 1'b1);
        run_of(1'b1, $urandom_range(0, 2), 1'b0);
        run_of(1'b0, 1, 1'b0);
      end
      6: begin
        if (inertia_set > 0) run_of(1'b1, $urandom_range(1, inertia_set), 1'b0);
        run_of(1'b0, 1, 1'b0);
      end
      7: begin
        // Noise with arbitrary timestamps, some of them stepping backwards.
        repeat ($urandom_range(1, 4)) begin
          send_sample(SAMPLE_WIDTH'($urandom),
                      ($urandom_range(0, 3) == 0) ? TIME_WIDTH'(0 - $urandom_range(1, 100))
                                                  : TIME_WIDTH'($urandom));
        end
      end
      8: run_of(1'($urandom_range(0, 1)), 1, 1'b1);
      default: begin
        click();
        click();
        run_of(1'b0, 1, 1'b1);
      end
    endcase
  endtask

  task automatic random_phase(input int beats);
    int stop;
    stop = beats_sent + beats;
    while (beats_sent < stop) random_sequence();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rcbcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcbcd_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [rcbcd_pkg::LEVEL_W-1:0] lvl,
                          input logic [rcbcd_pkg::INERTIA_W-1:0] lim,
                          input logic [rcbcd_pkg::HOLD_W-1:0] hold);
    drain();
    write_reg(rcbcd_pkg::REG_ACTIVE_LEVEL, {8'($urandom), lvl});
    write_reg(rcbcd_pkg::REG_INERTIA_LIMIT, {16'($urandom), lim});
    write_reg(rcbcd_pkg::REG_HOLD_TIME_US, hold);
    write_reg(REG_SPARE, rcbcd_pkg::CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    level_set = lvl;
    inertia_set = lim;
    hold_set = hold;
    now_us = $urandom;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: sample extremes, timestamp wrap, press, long press and a
    // release followed by a timestamp that steps backwards.
    send_sample(16'h7FFF, 32'd0);
    send_sample(16'h8000, 32'hFFFF_FFFF);
    send_sample(16'h0000, 32'd6);
    repeat (4) send_sample(16'h4000, 32'd1);
    send_sample(16'h4000, 32'd500001);
    send_sample(16'h0000, 32'd1);
    send_sample(16'h0000, 32'hFFFF_FFFF);
    click();
    click();

    // Zero level, zero inertia and zero hold time.
    set_regs(16'h0000, 8'd0, 24'd0);
    send_sample(16'h0000, 32'd0);
    send_sample(16'h0000, 32'd0);
    send_sample(16'h0000, 32'd1);
    send_sample(16'h0001, 32'd0);
    send_sample(16'h0001, 32'd1);

    set_regs(16'h4000, 8'd3, 24'd200);
    random_phase(250);

    // The sender floods while the result side holds off, so the input backs up.
    set_regs(16'h8000, 8'd0, 24'd1);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    random_phase(150);

    gaps_on = 1'b1;
    set_regs(16'h7FFF, 8'd255, 24'hFF_FFFF);
    random_phase(150);

    set_regs(16'h0000, 8'd2, 24'd0);
    random_phase(150);

    set_regs(16'($urandom), 8'($urandom_range(0, 6)), 24'($urandom_range(1, 5000)));
    random_phase(200);

    gaps_on = 1'b0;
    set_regs(16'hC000, 8'd1, 24'd1000);
    random_phase(150);

    drain();
    if (errors == 0) begin
      $display("rc_button_click_detector regression: pass");
    end else begin
      $display("rc_button_click_detector regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/rcbcd_pkg.sv
design/rcbcd_front.sv
design/rcbcd_queue.sv
design/rcbcd_back.sv
design/rc_button_click_detector.sv
tb/rc_button_click_detector_chk.sv
tb/rc_button_click_detector_tb.sv
